// ===== rtl/bcns_pkg.sv =====
// bcns_pkg: types and pattern constants for the beep code and number sequencer
// no dependencies
`timescale 1ns / 1ps
package bcns_pkg;

  typedef enum logic [1:0] {
    K_TICK = 2'd0,
    K_CODE = 2'd1,
    K_ALT  = 2'd2,
    K_STOP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_ENC_CODE = 2'd1,
    PH_ENC_ALT  = 2'd2,
    PH_PLAY     = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    C_WAIT, C_BCD, C_CHIRP, C_PAUSE, C_TENS, C_GAP_MID, C_UNITS, C_GAP_END,
    C_A2000, C_A500, C_A300, C_DIGIT, C_DGAP, C_END, C_RD, C_CHK
  } ctl_t;

  localparam int DUR_W = 11;
  localparam logic [DUR_W-1:0] D_CHIRP = 11'd30;
  localparam logic [DUR_W-1:0] D_BEEP  = 11'd100;
  localparam logic [DUR_W-1:0] D_BGAP  = 11'd200;
  localparam logic [DUR_W-1:0] D_DGAP  = 11'd300;
  localparam logic [DUR_W-1:0] D_DIG   = 11'd400;
  localparam logic [DUR_W-1:0] D_LONG  = 11'd500;
  localparam logic [DUR_W-1:0] D_LEAD  = 11'd2000;
  localparam logic [5:0] CHIRP_LAST = 6'd19;
  localparam logic [4:0] ZERO_BEEPS = 5'd10;
  localparam int BCD_DIGITS = 8;
  localparam logic [4:0] BIN_LAST = 5'd23;

endpackage

// ===== rtl/beep_code_and_number_sequencer_core.sv =====
// beep_code_and_number_sequencer_core: buzzer pattern encoder and player
// step store memory with registered read; uses bcns_pkg
//
// usage: one request channel (req_valid/req_ready) carries kind, status_code,
// repeat_total and altitude; one result channel (res_valid/res_ready) returns
// tone and busy_res for every accepted request.
// ticks while idle, playing ticks with time left, play and stop requests
// give their result in the cycle after acceptance.
// the first tick after a play request encodes the pattern into the step
// store, one step per cycle; for an altitude, binary to decimal conversion
// comes first and up to 124 steps follow. then playback starts.
// a tick that ends a step reads the store: each step looked at passes a read
// state and a check state, and at most four end marks are looked at per tick.
// one request is worked on at a time; req_ready is high only while the
// engine waits and the result register is free or being taken.
// a stalled receiver holds the result and blocks new requests.
// reset is synchronous: playback idle, internal tone level off, tone output and store contents undefined.
`timescale 1ns / 1ps
module beep_code_and_number_sequencer_core #(
  parameter int STEP_DEPTH = 128,
  parameter int MAX_DIGITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  status_code,
  input  logic [7:0]  repeat_total,
  input  logic signed [23:0] altitude,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        tone,
  output logic        busy_res
);
  import bcns_pkg::*;

  localparam int AW = $clog2(STEP_DEPTH);
  localparam int CW = $clog2(STEP_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STEP_DEPTH);
  localparam logic [CW-1:0] DEPTH_M1 = CW'(STEP_DEPTH - 1);

  logic [11:0] mem [STEP_DEPTH];
  logic [11:0] rd_data;

  ctl_t ctl, ctl_next;
  phase_t phase;
  logic tone_level;
  logic [CW-1:0] count, ptr, restart;
  logic [7:0] pass_limit, passes_done, held_code;
  logic [23:0] held_alt, bin;
  logic [DUR_W-1:0] ms_left;
  logic [4*BCD_DIGITS-1:0] bcd;
  logic [4:0] bcnt;
  logic [5:0] sidx;
  logic [2:0] dig_i;
  logic [1:0] iter;

  logic accept;
  logic put_en, put_end, put_ok;
  logic [11:0] put_word;
  logic [15:0] prod;
  logic [4:0] tens, units, beep_cnt, dcnt;
  logic [7:0] units8;
  logic [3:0] dsel;
  logic beep_last;
  logic [2:0] top;
  logic [23:0] mag;
  logic [4*BCD_DIGITS-1:0] bcd_adj;
  logic [DUR_W-1:0] ms_dec;
  logic [7:0] pd_inc;
  logic pass_more;

  assign req_ready = (ctl == C_WAIT) && (!res_valid || res_ready);
  assign accept = req_valid && req_ready;

  assign prod = 16'(held_code) * 16'd205;
  assign tens = (prod[15:11] == 5'd0) ? 5'd1 : prod[15:11];
  assign units8 = held_code - ({3'b0, prod[15:11]} * 8'd10);
  assign units = (units8[3:0] == 4'd0) ? 5'd1 : {1'b0, units8[3:0]};
  assign dsel = bcd[dig_i*4 +: 4];
  assign dcnt = (dsel == 4'd0) ? ZERO_BEEPS : {1'b0, dsel};
  assign mag = held_alt[23] ? 24'(-held_alt) : held_alt;
  assign ms_dec = (ms_left == '0) ? '0 : ms_left - 1'b1;
  assign pd_inc = passes_done + 8'd1;
  assign pass_more = (pass_limit == 8'd0) || (pd_inc < pass_limit);

  always_comb begin
    beep_cnt = (ctl == C_TENS) ? tens : (ctl == C_UNITS) ? units : dcnt;
    beep_last = (sidx == ({beep_cnt, 1'b0} - 6'd2));
    top = 3'd0;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (bcd[k*4 +: 4] != 4'd0) top = 3'(k);
    end
    if (int'(top) > MAX_DIGITS - 1) top = 3'(MAX_DIGITS - 1);
    for (int k = 0; k < BCD_DIGITS; k++) begin
      bcd_adj[k*4 +: 4] = (bcd[k*4 +: 4] >= 4'd5) ? bcd[k*4 +: 4] + 4'd3 : bcd[k*4 +: 4];
    end
  end

  always_comb begin
    ctl_next = ctl;
    put_en = 1'b0;
    put_end = 1'b0;
    put_word = 12'd0;
    case (ctl)
      C_WAIT: begin
        if (accept && kind == K_TICK) begin
          case (phase)
            PH_ENC_CODE: ctl_next = C_CHIRP;
            PH_ENC_ALT:  ctl_next = C_BCD;
            PH_PLAY:     if (ms_dec == '0) ctl_next = C_RD;
            default:     ctl_next = C_WAIT;
          endcase
        end
      end
      C_BCD: if (bcnt == BIN_LAST) ctl_next = C_A2000;
      C_CHIRP: begin
        put_en = 1'b1;
        put_word = {~sidx[0], D_CHIRP};
        if (sidx == CHIRP_LAST) ctl_next = C_PAUSE;
      end
      C_PAUSE: begin
        put_en = 1'b1;
        put_word = {1'b0, D_LONG};
        ctl_next = C_TENS;
      end
      C_TENS, C_UNITS, C_DIGIT: begin
        put_en = 1'b1;
        put_word = sidx[0] ? {1'b0, D_BGAP} : {1'b1, D_BEEP};
        if (beep_last) begin
          ctl_next = (ctl == C_TENS) ? C_GAP_MID : (ctl == C_UNITS) ? C_GAP_END : C_DGAP;
        end
      end
      C_GAP_MID: begin
        put_en = 1'b1;
        put_word = {1'b0, D_DGAP};
        ctl_next = C_UNITS;
      end
      C_GAP_END: begin
        put_en = 1'b1;
        put_word = {1'b0, D_LONG};
        ctl_next = C_END;
      end
      C_A2000: begin
        put_en = 1'b1;
        put_word = {1'b0, D_LEAD};
        ctl_next = C_A500;
      end
      C_A500: begin
        put_en = 1'b1;
        put_word = {1'b1, D_LONG};
        ctl_next = C_A300;
      end
      C_A300: begin
        put_en = 1'b1;
        put_word = {1'b0, D_DGAP};
        ctl_next = C_DIGIT;
      end
      C_DGAP: begin
        put_en = 1'b1;
        put_word = {1'b0, D_DIG};
        ctl_next = (dig_i == 3'd0) ? C_END : C_DIGIT;
      end
      C_END: begin
        put_en = 1'b1;
        put_end = 1'b1;
        ctl_next = C_RD;
      end
      C_RD: ctl_next = (ptr >= count) ? C_WAIT : C_CHK;
      C_CHK: begin
        if (rd_data[DUR_W-1:0] == '0 && pass_more && iter != 2'd3) ctl_next = C_RD;
        else ctl_next = C_WAIT;
      end
      default: ctl_next = C_WAIT;
    endcase
    put_ok = put_en && (put_end ? (count < DEPTH_C) : (count < DEPTH_M1));
  end

  always_ff @(posedge clk) begin
    if (rst) ctl <= C_WAIT;
    else ctl <= ctl_next;
  end

  // step store
  always_ff @(posedge clk) begin
    if (put_ok) mem[count[AW-1:0]] <= put_word;
    rd_data <= mem[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      tone_level <= 1'b0;
      count <= '0;
      ptr <= '0;
      restart <= '0;
      pass_limit <= 8'd0;
      passes_done <= 8'd0;
      ms_left <= '0;
      held_code <= 8'd0;
      held_alt <= 24'd0;
      res_valid <= 1'b0;
      iter <= 2'd0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (put_ok) count <= count + 1'b1;
      if (ctl_next != ctl) sidx <= 6'd0;
      else if (put_en) sidx <= sidx + 6'd1;
      case (ctl)
        C_WAIT: begin
          if (accept) begin
            case (kind_t'(kind))
              K_TICK: begin
                iter <= 2'd0;
                case (phase)
                  PH_ENC_CODE, PH_ENC_ALT: begin
                    count <= '0;
                    passes_done <= 8'd0;
                    ptr <= '0;
                    ms_left <= '0;
                    bin <= mag;
                    bcd <= '0;
                    bcnt <= 5'd0;
                    if (phase == PH_ENC_ALT) pass_limit <= 8'd0;
                  end
                  PH_PLAY: begin
                    ms_left <= ms_dec;
                    if (ms_dec != '0) begin
                      res_valid <= 1'b1;
                      tone <= tone_level;
                      busy_res <= 1'b1;
                    end
                  end
                  default: begin
                    res_valid <= 1'b1;
                    tone <= tone_level;
                    busy_res <= 1'b0;
                  end
                endcase
              end
              K_CODE: begin
                tone_level <= 1'b0;
                held_code <= status_code;
                pass_limit <= repeat_total;
                passes_done <= 8'd0;
                ptr <= '0;
                ms_left <= '0;
                phase <= PH_ENC_CODE;
                res_valid <= 1'b1;
                tone <= 1'b0;
                busy_res <= 1'b1;
              end
              K_ALT: begin
                tone_level <= 1'b0;
                held_alt <= altitude;
                ptr <= '0;
                ms_left <= '0;
                phase <= PH_ENC_ALT;
                res_valid <= 1'b1;
                tone <= 1'b0;
                busy_res <= 1'b1;
              end
              default: begin
                tone_level <= 1'b0;
                phase <= PH_IDLE;
                res_valid <= 1'b1;
                tone <= 1'b0;
                busy_res <= 1'b0;
              end
            endcase
          end
        end
        C_BCD: begin
          bcd <= {bcd_adj[4*BCD_DIGITS-2:0], bin[23]};
          bin <= {bin[22:0], 1'b0};
          bcnt <= bcnt + 5'd1;
        end
        C_PAUSE: restart <= put_ok ? count + 1'b1 : count;
        C_A2000: restart <= '0;
        C_A300: dig_i <= top;
        C_DGAP: if (dig_i != 3'd0) dig_i <= dig_i - 3'd1;
        C_END: begin
          phase <= PH_PLAY;
          ptr <= '0;
          iter <= 2'd0;
        end
        C_RD: begin
          if (ptr >= count) begin
            phase <= PH_IDLE;
            tone_level <= 1'b0;
            res_valid <= 1'b1;
            tone <= 1'b0;
            busy_res <= 1'b0;
          end
        end
        C_CHK: begin
          if (rd_data[DUR_W-1:0] == '0) begin
            passes_done <= pd_inc;
            if (pass_more) begin
              ptr <= restart;
              iter <= iter + 2'd1;
              if (iter == 2'd3) begin
                res_valid <= 1'b1;
                tone <= tone_level;
                busy_res <= 1'b1;
              end
            end else begin
              phase <= PH_IDLE;
              tone_level <= 1'b0;
              res_valid <= 1'b1;
              tone <= 1'b0;
              busy_res <= 1'b0;
            end
          end else begin
            tone_level <= rd_data[11];
            ms_left <= rd_data[DUR_W-1:0];
            ptr <= ptr + 1'b1;
            res_valid <= 1'b1;
            tone <= rd_data[11];
            busy_res <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // held_alt is captured for the pattern; magnitude is taken at the encode tick
  logic alt_match;
  assign alt_match = (held_alt == altitude);

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("step count beyond store depth");
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PLAY) |-> (ptr <= count))
    else $error("step pointer beyond stored steps");
  a_chk_after_rd: assert property (@(posedge clk) disable iff (rst)
    (ctl == C_CHK) |-> ($past(ctl) == C_RD))
    else $error("store check without read");
  a_rest_free: assert property (@(posedge clk) disable iff (rst)
    (ctl != C_WAIT && ctl != C_RD && ctl != C_CHK && ctl != C_BCD) |-> put_en)
    else $error("encode state without store write");
  a_alt_held: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == K_ALT) |=> (alt_match || !$stable(altitude)))
    else $error("altitude request not held");

endmodule
